### rtl/fexc_pkg.sv
// ---------------------------------------------------------------------------
// fexc_pkg: shared types and constants for the fermionic excitation block
// Widths of the state word, the index registers and the phase code, and the
// decoded operator that travels from the index decoder to the datapath.
// ---------------------------------------------------------------------------
package fexc_pkg;

    localparam int StateW = 32;
    localparam int IdxW   = 5;
    localparam int SIdxW  = 6;
    localparam int PhaseW = 2;
    localparam int CfgIdxW = 2;

    // Register indices of the configuration port.
    localparam logic [CfgIdxW-1:0] RegIndexOne   = 2'd0;
    localparam logic [CfgIdxW-1:0] RegIndexTwo   = 2'd1;
    localparam logic [CfgIdxW-1:0] RegIndexThree = 2'd2;
    localparam logic [CfgIdxW-1:0] RegIndexFour  = 2'd3;

    // Phase codes of the matrix element.
    localparam logic [PhaseW-1:0] PhasePlusOne  = 2'd0;
    localparam logic [PhaseW-1:0] PhaseMinusOne = 2'd1;
    localparam logic [PhaseW-1:0] PhasePlusI    = 2'd2;
    localparam logic [PhaseW-1:0] PhaseMinusI   = 2'd3;

    // Operator decoded from the four index registers.
    typedef struct packed {
        logic [StateW-1:0] create;
        logic [StateW-1:0] annih;
        logic [StateW-1:0] sign_mask;
        logic              neg_base;
        logic              number_op;
    } t_op;

endpackage

### rtl/fexc_op_decode.sv
// ---------------------------------------------------------------------------
// fexc_op_decode: index registers to operator masks
// Forms the create, annihilate and sign masks, the ordering sign and the
// number-operator flag from the configured orbital indices.
// ---------------------------------------------------------------------------
module fexc_op_decode (
    input  logic [fexc_pkg::IdxW-1:0]  i_index_one,
    input  logic [fexc_pkg::IdxW-1:0]  i_index_two,
    input  logic [fexc_pkg::SIdxW-1:0] i_index_three,
    input  logic [fexc_pkg::SIdxW-1:0] i_index_four,
    output fexc_pkg::t_op              o_op
);
    import fexc_pkg::*;

    logic [IdxW-1:0]   idx_three;
    logic [IdxW-1:0]   idx_four;
    logic              double_mode;
    logic [StateW-1:0] one_hot_one;
    logic [StateW-1:0] one_hot_two;
    logic [StateW-1:0] one_hot_three;
    logic [StateW-1:0] one_hot_four;
    logic [StateW-1:0] below_one;
    logic [StateW-1:0] below_two;
    logic [StateW-1:0] below_three;
    logic [StateW-1:0] below_four;

    assign idx_three   = i_index_three[IdxW-1:0];
    assign idx_four    = i_index_four[IdxW-1:0];
    assign double_mode = !i_index_three[SIdxW-1] && !i_index_four[SIdxW-1];

    assign one_hot_one   = StateW'(1) << i_index_one;
    assign one_hot_two   = StateW'(1) << i_index_two;
    assign one_hot_three = StateW'(1) << idx_three;
    assign one_hot_four  = StateW'(1) << idx_four;

    // All bits strictly below each index.
    assign below_one   = one_hot_one   - StateW'(1);
    assign below_two   = one_hot_two   - StateW'(1);
    assign below_three = one_hot_three - StateW'(1);
    assign below_four  = one_hot_four  - StateW'(1);

    always_comb begin
        if (double_mode) begin
            o_op.create    = one_hot_one | one_hot_two;
            o_op.annih     = one_hot_three | one_hot_four;
            o_op.sign_mask = (below_one ^ below_two ^ below_three ^ below_four)
                             & ~(o_op.create | o_op.annih);
            o_op.neg_base  = (i_index_one > i_index_two) ^ (idx_three > idx_four);
        end else begin
            o_op.create    = one_hot_one;
            o_op.annih     = one_hot_two;
            o_op.sign_mask = (below_one ^ below_two) & ~(o_op.create | o_op.annih);
            o_op.neg_base  = 1'b0;
        end
        o_op.number_op = (o_op.create == o_op.annih);
    end

endmodule

### rtl/fermionic_excitation_apply.sv
// ---------------------------------------------------------------------------
// fermionic_excitation_apply: one excitation operator on one basis state
// Applies an anti-Hermitian fermionic excitation operator in the
// Jordan-Wigner mapping to an occupation-bit basis state and returns the
// non-zero matrix element as source, target and phase code.
// ---------------------------------------------------------------------------
//
//  Channel  | Ports                                   | Handshake
//  ---------+-----------------------------------------+---------------------------
//  input    | start, busy, i_basis_state              | taken when start && !busy
//  result   | o_result_valid, o_source_state,         | one-cycle strobe, no stall
//           | o_target_state, o_phase_code            |
//  config   | i_cfg_we, i_cfg_index, i_cfg_data       | written when i_cfg_we
//
// A word enters every cycle and its result, if the matrix element is
// non-zero, leaves through the stages in order: stage one registers the
// masked state, stage two forms the occupancy tests and byte-wise sign
// parity, stage three folds the parity and registers the outputs.
// busy is held low, since the receiver cannot stall and nothing backs up.
// The synchronous active-low reset clears the valid bits and loads the
// index registers with their reset values.
//
module fermionic_excitation_apply #(
    parameter int QUBITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [fexc_pkg::StateW-1:0]   i_basis_state,
    input  logic                          i_cfg_we,
    input  logic [fexc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [fexc_pkg::SIdxW-1:0]    i_cfg_data,
    output logic                          o_result_valid,
    output logic [fexc_pkg::StateW-1:0]   o_source_state,
    output logic [fexc_pkg::StateW-1:0]   o_target_state,
    output logic [fexc_pkg::PhaseW-1:0]   o_phase_code
);
    import fexc_pkg::*;

    // Bits at or above QUBITS are cleared on entry.
    localparam logic [StateW-1:0] StateMask =
        (QUBITS >= StateW) ? {StateW{1'b1}} : StateW'((64'd1 << QUBITS) - 64'd1);
    localparam int Groups = StateW / 8;

    // Configuration registers.
    logic [IdxW-1:0]  r_index_one;
    logic [IdxW-1:0]  r_index_two;
    logic [SIdxW-1:0] r_index_three;
    logic [SIdxW-1:0] r_index_four;

    t_op op;

    // Stage one.
    logic              r_s1_valid;
    logic [StateW-1:0] r_s1_basis;

    // Stage two.
    logic              r_s2_valid;
    logic [StateW-1:0] r_s2_basis;
    logic [StateW-1:0] r_s2_target;
    logic [Groups-1:0] r_s2_parity;
    logic              r_s2_neg;
    logic              r_s2_imag;

    logic [Groups-1:0] n_s2_parity;
    logic              n_s2_hit;
    logic              n_s2_neg;
    logic              annih_full;
    logic              create_full;
    logic              create_only_empty;
    logic              annih_only_empty;
    logic [StateW-1:0] signed_bits;

    // Config writes are for the user to make only while the pipeline is empty; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_one   <= IdxW'(0);
            r_index_two   <= IdxW'(1);
            r_index_three <= {SIdxW{1'b1}};
            r_index_four  <= {SIdxW{1'b1}};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegIndexOne:   r_index_one   <= i_cfg_data[IdxW-1:0];
                RegIndexTwo:   r_index_two   <= i_cfg_data[IdxW-1:0];
                RegIndexThree: r_index_three <= i_cfg_data;
                RegIndexFour:  r_index_four  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fexc_op_decode u_op_decode (
        .i_index_one   (r_index_one),
        .i_index_two   (r_index_two),
        .i_index_three (r_index_three),
        .i_index_four  (r_index_four),
        .o_op          (op)
    );

    assign busy = 1'b0;

    // Stage two logic: occupancy tests and partial sign parity.
    assign signed_bits       = r_s1_basis & op.sign_mask;
    assign annih_full        = (r_s1_basis & op.annih) == op.annih;
    assign create_full       = (r_s1_basis & op.create) == op.create;
    assign create_only_empty = (r_s1_basis & op.create & ~op.annih) == '0;
    assign annih_only_empty  = (r_s1_basis & op.annih & ~op.create) == '0;

    always_comb begin
        for (int g = 0; g < Groups; g++) begin
            n_s2_parity[g] = ^signed_bits[g*8 +: 8];
        end
        // The number operator is tested first, then the forward excitation,
        // then the reverse one; only the reverse case adds a sign flip.
        if (op.number_op) begin
            n_s2_hit = annih_full;
            n_s2_neg = op.neg_base;
        end else if (annih_full && create_only_empty) begin
            n_s2_hit = 1'b1;
            n_s2_neg = op.neg_base;
        end else if (create_full && annih_only_empty) begin
            n_s2_hit = 1'b1;
            n_s2_neg = !op.neg_base;
        end else begin
            n_s2_hit = 1'b0;
            n_s2_neg = op.neg_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_s1_valid     <= start && !busy;
            r_s2_valid     <= r_s1_valid && n_s2_hit;
            o_result_valid <= r_s2_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_s1_basis <= i_basis_state & StateMask;

        r_s2_basis  <= r_s1_basis;
        // Swapping create and annihilate bits covers both directions and
        // leaves the state unchanged for the number operator.
        r_s2_target <= r_s1_basis ^ op.create ^ op.annih;
        r_s2_parity <= n_s2_parity;
        r_s2_neg    <= n_s2_neg;
        r_s2_imag   <= op.number_op;

        o_source_state <= r_s2_basis;
        o_target_state <= r_s2_target;
        if ((r_s2_neg ^ (^r_s2_parity)) == 1'b0) begin
            o_phase_code <= r_s2_imag ? PhasePlusI : PhasePlusOne;
        end else begin
            o_phase_code <= r_s2_imag ? PhaseMinusI : PhaseMinusOne;
        end
    end

endmodule
